// ===== rtl/core/lsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types, codes and constants of the lens stepper position controller.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int VAL_W          = 16;  // width of value field and config regs
  localparam int POS_WIDTH_DEF  = 16;
  localparam int WAIT_WIDTH_DEF = 16;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [VAL_W-1:0] MAX_POS_RST    = 16'd0;
  localparam logic [VAL_W-1:0] STEP_IVAL_RST  = 16'd3333;
  localparam logic [VAL_W-1:0] HOME_SWEEP_RST = 16'd2500;

  // Coil drive bits, A+ A- B+ B- from msb
  localparam logic [3:0] COIL_AP  = 4'h8;
  localparam logic [3:0] COIL_AN  = 4'h4;
  localparam logic [3:0] COIL_BP  = 4'h2;
  localparam logic [3:0] COIL_BN  = 4'h1;
  localparam logic [3:0] COIL_OFF = 4'h0;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_STEP    = 3'd1,
    OP_GOTO    = 3'd2,
    OP_ABORT   = 3'd3,
    OP_RELEASE = 3'd4,
    OP_HOME    = 3'd5,
    OP_SETPOS  = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_LIMIT = 3'd2,
    ST_ABORT = 3'd3,
    ST_BUSY  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_MAX_POS    = 2'd0,
    REG_STEP_IVAL  = 2'd1,
    REG_HOME_SWEEP = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_WAIT = 4'b0010,
    MODE_GOTO = 4'b0100,
    MODE_HOME = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [VAL_W-1:0] max_position;
    logic [VAL_W-1:0] step_interval;
    logic [VAL_W-1:0] home_sweep_steps;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       op;
    logic             direction;
    logic [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic    busy;
    status_e status;
    logic    done;
  } flags_t;

  // Full-step phase pattern 9, A, 6, 5
  function automatic logic [3:0] phase_coils(input logic [1:0] ph);
    logic [3:0] c;
    case (ph)
      2'd0:    c = COIL_AP | COIL_BN;
      2'd1:    c = COIL_AP | COIL_BP;
      2'd2:    c = COIL_AN | COIL_BP;
      2'd3:    c = COIL_AN | COIL_BN;
      default: c = COIL_OFF;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lsp_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_cfg_regs
// APB register file: max position, step interval, homing sweep length.
// ----------------------------------------------------------------------------
module lsp_cfg_regs
  import lsp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MAX_POS:    cfg_d.max_position     = pwdata[VAL_W-1:0];
        REG_STEP_IVAL:  cfg_d.step_interval    = pwdata[VAL_W-1:0];
        REG_HOME_SWEEP: cfg_d.home_sweep_steps = pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_POS:    prdata = APB_DW'(cfg_q.max_position);
      REG_STEP_IVAL:  prdata = APB_DW'(cfg_q.step_interval);
      REG_HOME_SWEEP: prdata = APB_DW'(cfg_q.home_sweep_steps);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_position     <= MAX_POS_RST;
      cfg_q.step_interval    <= STEP_IVAL_RST;
      cfg_q.home_sweep_steps <= HOME_SWEEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lsp_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_step_unit
// Axis state (position, coils, mode, target, sweep and wait counters) and
// the single-pass next-state logic for one request.
// ----------------------------------------------------------------------------
module lsp_step_unit
  import lsp_pkg::*;
#(
  parameter int POS_WIDTH  = POS_WIDTH_DEF,
  parameter int WAIT_WIDTH = WAIT_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire item_t                item_i,
  input  wire cfg_t                 cfg_i,
  output logic [3:0]                coils_o,
  output logic [POS_WIDTH-1:0]      position_o,
  output flags_t                    flags_o
);

  // compare width covering both position and value ranges, plus carry
  localparam int CW = ((POS_WIDTH > VAL_W) ? POS_WIDTH : VAL_W) + 1;

  logic [POS_WIDTH-1:0]  pos_q, pos_d;
  logic [3:0]            coil_q, coil_d;
  mode_e                 mode_q, mode_d;
  logic [VAL_W-1:0]      tgt_q, tgt_d;
  logic [WAIT_WIDTH-1:0] sweep_q, sweep_d;
  logic [WAIT_WIDTH-1:0] wait_q, wait_d;

  op_e                   op;
  logic                  busy;
  logic [WAIT_WIDTH-1:0] wait_dec, wait_cfg, wait_load;
  logic [WAIT_WIDTH-1:0] sweep_src;
  logic                  drive_dir, drive_ok, drive_en, home_en;
  logic [POS_WIDTH-1:0]  drive_pos;
  status_e               status;
  logic                  done;

  assign op   = op_e'(item_i.op);
  assign busy = (mode_q != MODE_IDLE);

  assign wait_dec  = (wait_q == '0) ? wait_q : wait_q - WAIT_WIDTH'(1);
  assign wait_cfg  = WAIT_WIDTH'(cfg_i.step_interval);
  assign wait_load = (wait_cfg == '0) ? WAIT_WIDTH'(1) : wait_cfg;
  assign sweep_src = (op == OP_HOME) ? WAIT_WIDTH'(cfg_i.home_sweep_steps) : sweep_q;

  // one phase per request at most; pick its direction by command
  always_comb begin
    case (op)
      OP_STEP: drive_dir = item_i.direction;
      OP_GOTO: drive_dir = CW'(item_i.value) > CW'(pos_q);
      default: drive_dir = CW'(tgt_q) > CW'(pos_q);
    endcase
  end

  assign drive_ok  = drive_dir ? ((CW'(pos_q) + CW'(1)) < CW'(cfg_i.max_position))
                               : (pos_q != '0);
  assign drive_pos = drive_dir ? pos_q + POS_WIDTH'(1) : pos_q - POS_WIDTH'(1);

  always_comb begin
    pos_d    = pos_q;
    coil_d   = coil_q;
    mode_d   = mode_q;
    tgt_d    = tgt_q;
    sweep_d  = sweep_q;
    wait_d   = wait_q;
    status   = ST_OK;
    done     = 1'b0;
    drive_en = 1'b0;
    home_en  = 1'b0;

    case (op)
      OP_TICK: begin
        if (busy) begin
          wait_d = wait_dec;
          if (wait_dec == '0) begin
            case (mode_q)
              MODE_WAIT: begin
                mode_d = MODE_IDLE;
                done   = 1'b1;
              end
              MODE_GOTO: begin
                if (CW'(pos_q) == CW'(tgt_q)) begin
                  mode_d = MODE_IDLE;
                  done   = 1'b1;
                end else begin
                  drive_en = 1'b1;
                  if (!drive_ok) begin
                    mode_d = MODE_IDLE;
                    status = ST_LIMIT;
                    done   = 1'b1;
                  end
                end
              end
              MODE_HOME: home_en = 1'b1;
              default: ;
            endcase
          end
        end
      end
      OP_ABORT: begin
        if (mode_q == MODE_GOTO) begin
          mode_d = MODE_IDLE;
          wait_d = '0;
          status = ST_ABORT;
        end
      end
      OP_STEP: begin
        if (busy) begin
          status = ST_BUSY;
        end else begin
          drive_en = 1'b1;
          if (drive_ok) mode_d = MODE_WAIT;
          else          status = ST_LIMIT;
        end
      end
      OP_GOTO: begin
        if (busy) begin
          status = ST_BUSY;
        end else if (item_i.value >= cfg_i.max_position) begin
          status = ST_RANGE;
        end else if (CW'(item_i.value) == CW'(pos_q)) begin
          done = 1'b1;
        end else begin
          tgt_d    = item_i.value;
          drive_en = 1'b1;
          if (drive_ok) begin
            mode_d = MODE_GOTO;
          end else begin
            status = ST_LIMIT;
            done   = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (busy) status = ST_BUSY;
        else      coil_d = COIL_OFF;
      end
      OP_HOME: begin
        if (busy) begin
          status = ST_BUSY;
        end else begin
          mode_d  = MODE_HOME;
          home_en = 1'b1;
        end
      end
      OP_SETPOS: begin
        if (busy) status = ST_BUSY;
        else      pos_d = POS_WIDTH'(item_i.value);
      end
      default: ;
    endcase

    if (drive_en) begin
      if (drive_ok) begin
        pos_d  = drive_pos;
        coil_d = phase_coils(drive_pos[1:0]);
        wait_d = wait_load;
      end else begin
        coil_d = COIL_OFF;
      end
    end

    if (home_en) begin
      if (sweep_src == '0) begin
        coil_d  = COIL_OFF;
        pos_d   = '0;
        mode_d  = MODE_IDLE;
        sweep_d = sweep_src;
        done    = 1'b1;
      end else begin
        coil_d  = phase_coils(sweep_src[1:0]);
        sweep_d = sweep_src - WAIT_WIDTH'(1);
        wait_d  = wait_load;
      end
    end
  end

  assign coils_o        = coil_d;
  assign position_o     = pos_d;
  assign flags_o.busy   = (mode_d != MODE_IDLE);
  assign flags_o.status = status;
  assign flags_o.done   = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      coil_q  <= COIL_OFF;
      mode_q  <= MODE_IDLE;
      tgt_q   <= '0;
      sweep_q <= '0;
      wait_q  <= '0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      coil_q  <= coil_d;
      mode_q  <= mode_d;
      tgt_q   <= tgt_d;
      sweep_q <= sweep_d;
      wait_q  <= wait_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lens_stepper_position_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lens_stepper_position_controller
// One lens axis driven by a four-phase full-step stepper motor.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_ready_o): op, direction, value. Ticks
//   (op 0) advance time; the other ops are commands (step, goto, abort,
//   release, home, set position). Every request yields exactly one result.
//   Result channel (out_valid_o / out_ready_i): coils, position, busy,
//   status, done.
//   Path: an accepted request is held in the input register, then its result
//   in the result register. Throughput: one request per clock,
//   limited only by the result handshake; the step unit's state update is
//   a single pass.
//   Receiver stall: the result register holds; one more request may sit in
//   the input register, after which in_ready_o drops.
//   Config: APB port, registers at 0x0 max_position, 0x4 step_interval,
//   0x8 home_sweep_steps; pready is always high. Write only while idle.
//   Reset: coils released, position 0, mode idle, interval 3333, sweep
//   2500, max_position 0 (so every goto is out of range until written).
// ----------------------------------------------------------------------------
module lens_stepper_position_controller
  import lsp_pkg::*;
#(
  parameter int POS_WIDTH  = POS_WIDTH_DEF,
  parameter int WAIT_WIDTH = WAIT_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // config port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [APB_AW-1:0]    paddr,
  input  wire logic [APB_DW-1:0]    pwdata,
  output logic      [APB_DW-1:0]    prdata,
  output logic                      pready,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [2:0]           op_i,
  input  wire logic                 direction_i,
  input  wire logic [VAL_W-1:0]     value_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [3:0]                coils_o,
  output logic [POS_WIDTH-1:0]      position_o,
  output logic                      busy_res_o,
  output logic [2:0]                status_o,
  output logic                      done_res_o
);

  cfg_t                 cfg;

  // input register
  logic                 in_valid_q;
  item_t                item_q;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [3:0]           coils_q;
  logic [POS_WIDTH-1:0] pos_q;
  flags_t               flags_q;

  logic [3:0]           coils_nxt;
  logic [POS_WIDTH-1:0] pos_nxt;
  flags_t               flags_nxt;

  logic                 advance;   // result slot free this cycle
  logic                 fire;      // buffered request processed this cycle

  lsp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.op        <= op_i;
      item_q.direction <= direction_i;
      item_q.value     <= value_i;
    end
  end

  lsp_step_unit #(
    .POS_WIDTH  (POS_WIDTH),
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item_q),
    .cfg_i      (cfg),
    .coils_o    (coils_nxt),
    .position_o (pos_nxt),
    .flags_o    (flags_nxt)
  );

  always_comb begin
    if (fire)             out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      coils_q <= coils_nxt;
      pos_q   <= pos_nxt;
      flags_q <= flags_nxt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign coils_o     = coils_q;
  assign position_o  = pos_q;
  assign busy_res_o  = flags_q.busy;
  assign status_o    = flags_q.status;
  assign done_res_o  = flags_q.done;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a finished move or homing leaves the axis idle
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  // a busy rejection only happens with a move in progress
  a_busy_rej : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BUSY) |-> busy_res_o)
    else $error("busy rejection while idle");

  // hitting a limit always releases the coils
  a_limit_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_LIMIT) |-> (coils_o == COIL_OFF))
    else $error("coils still driven at limit");

  // coils are either released or one full-step pattern (two coils on)
  a_coil_pat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coils_o == COIL_OFF) || ($countones(coils_o) == 2))
    else $error("illegal coil pattern");

  // a stalled result frees no slot, so a buffered request must stay put
  a_hold_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_o && !out_ready_i |=> in_valid_q)
    else $error("buffered request lost during stall");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lens stepper position controller. Requests
// are driven over valid/ready with random gaps, results are drained with
// random and long stalls, and every result is compared against a cycle-free
// prediction of the axis state. Registers are set over APB between phases.
// ----------------------------------------------------------------------------
module tb_top
  import lsp_pkg::*;
;

  localparam int POS_W          = POS_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
  localparam int DRAIN_CYCLES   = 6;     // two-stage pipe plus margin
  localparam int RX_HOLD_CYCLES = 120;   // long result stall, fills the pipe
  localparam int CHUNK_ITEMS    = 67;
  localparam int CHUNKS_PER_PH  = 4;
  localparam int HOME_TICKS     = 8;     // first phases of a full-width sweep

  // expected result of one request
  typedef struct {
    logic [3:0]       coils;
    logic [POS_W-1:0] position;
    logic             busy;
    status_e          status;
    logic             done;
  } lens_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks axis state per accepted request and holds the
  // results still owed by the block, oldest first.
  // --------------------------------------------------------------------------
  class lens_axis_scoreboard;
    cfg_t             cfg;
    logic [POS_W-1:0] cur_pos;
    logic [POS_W-1:0] target_pos;
    logic [15:0]      sweep_left;
    logic [15:0]      wait_left;
    logic [3:0]       coil_state;
    mode_e            mode;
    lens_result_t     expected_results[$];
    int               fail_count;

    function new();
      cfg.max_position     = MAX_POS_RST;
      cfg.step_interval    = STEP_IVAL_RST;
      cfg.home_sweep_steps = HOME_SWEEP_RST;
      cur_pos    = '0;
      target_pos = '0;
      sweep_left = '0;
      wait_left  = '0;
      coil_state = COIL_OFF;
      mode       = MODE_IDLE;
      fail_count = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [15:0] v);
      case (idx)
        REG_MAX_POS:    cfg.max_position     = v;
        REG_STEP_IVAL:  cfg.step_interval    = v;
        REG_HOME_SWEEP: cfg.home_sweep_steps = v;
        default: ;
      endcase
    endfunction

    // full-step sequence 9, A, 6, 5
    function logic [3:0] pattern_of(logic [1:0] ph);
      case (ph)
        2'd0:    return 4'h9;
        2'd1:    return 4'hA;
        2'd2:    return 4'h6;
        default: return 4'h5;
      endcase
    endfunction

    function void load_wait();
      wait_left = (cfg.step_interval == 0) ? 16'd1 : cfg.step_interval;
    endfunction

    // one phase; 0 means a limit was hit and the coils were released
    function bit drive_phase(bit fwd);
      if (fwd) begin
        if ({1'b0, cur_pos} + 1 >= {1'b0, cfg.max_position}) begin
          coil_state = COIL_OFF;
          return 1'b0;
        end
        cur_pos = cur_pos + 1'b1;
      end else begin
        if (cur_pos == 0) begin
          coil_state = COIL_OFF;
          return 1'b0;
        end
        cur_pos = cur_pos - 1'b1;
      end
      coil_state = pattern_of(cur_pos[1:0]);
      load_wait();
      return 1'b1;
    endfunction

    // next homing phase; 1 when homing has finished
    function bit home_next();
      if (sweep_left == 0) begin
        coil_state = COIL_OFF;
        cur_pos    = '0;
        mode       = MODE_IDLE;
        return 1'b1;
      end
      coil_state = pattern_of(sweep_left[1:0]);
      sweep_left = sweep_left - 1'b1;
      load_wait();
      return 1'b0;
    endfunction

    function void note_request(op_e op, logic dir, logic [15:0] val);
      status_e      st;
      logic         done;
      lens_result_t r;
      st   = ST_OK;
      done = 1'b0;
      if (op == OP_TICK) begin
        if (mode != MODE_IDLE) begin
          if (wait_left != 0) wait_left = wait_left - 1'b1;
          if (wait_left == 0) begin
            case (mode)
              MODE_WAIT: begin
                mode = MODE_IDLE;
                done = 1'b1;
              end
              MODE_GOTO: begin
                if (cur_pos == target_pos) begin
                  mode = MODE_IDLE;
                  done = 1'b1;
                end else if (!drive_phase(target_pos > cur_pos)) begin
                  mode = MODE_IDLE;
                  st   = ST_LIMIT;
                  done = 1'b1;
                end
              end
              default: done = home_next();
            endcase
          end
        end
      end else if (op == OP_ABORT) begin
        if (mode == MODE_GOTO) begin
          mode      = MODE_IDLE;
          wait_left = '0;
          st        = ST_ABORT;
        end
      end else if (op == OP_NONE) begin
        // unused op, nothing changes
      end else if (mode != MODE_IDLE) begin
        st = ST_BUSY;
      end else begin
        case (op)
          OP_STEP: begin
            if (drive_phase(dir)) mode = MODE_WAIT;
            else st = ST_LIMIT;
          end
          OP_GOTO: begin
            if (val >= cfg.max_position) begin
              st = ST_RANGE;
            end else if (val == cur_pos) begin
              done = 1'b1;
            end else begin
              target_pos = val;
              if (drive_phase(val > cur_pos)) begin
                mode = MODE_GOTO;
              end else begin
                st   = ST_LIMIT;
                done = 1'b1;
              end
            end
          end
          OP_RELEASE: coil_state = COIL_OFF;
          OP_HOME: begin
            sweep_left = cfg.home_sweep_steps;
            mode       = MODE_HOME;
            done       = home_next();
          end
          default: cur_pos = val;  // set position, no range check
        endcase
      end
      r.coils    = coil_state;
      r.position = cur_pos;
      r.busy     = (mode != MODE_IDLE);
      r.status   = st;
      r.done     = done;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [3:0] coils, logic [POS_W-1:0] pos, logic busy,
                               logic [2:0] st, logic done);
      lens_result_t r;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: coils %h position %0d", coils, pos);
        fail_count++;
        return;
      end
      r = expected_results.pop_front();
      if (coils !== r.coils) begin
        $error("coils: expected %h, got %h", r.coils, coils);
        fail_count++;
      end
      if (pos !== r.position) begin
        $error("position: expected %0d, got %0d", r.position, pos);
        fail_count++;
      end
      if (busy !== r.busy) begin
        $error("busy_res: expected %0b, got %0b", r.busy, busy);
        fail_count++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        fail_count++;
      end
      if (done !== r.done) begin
        $error("done_res: expected %0b, got %0b", r.done, done);
        fail_count++;
      end
    endfunction
  endclass

  lens_axis_scoreboard sb = new();

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [2:0]        op_i        = OP_TICK;
  logic              direction_i = 1'b0;
  logic [VAL_W-1:0]  value_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [3:0]        coils_o;
  logic [POS_W-1:0]  position_o;
  logic              busy_res_o;
  logic [2:0]        status_o;
  logic              done_res_o;

  // idle rates in percent, set per phase by the main sequence
  int unsigned tx_idle_pct = 35;
  int unsigned rx_idle_pct = 58;
  logic [15:0] cur_max     = MAX_POS_RST;  // used to aim random targets

  // long receiver stall: requested by the main sequence, counted here
  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  lens_stepper_position_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .direction_i (direction_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .coils_o     (coils_o),
    .position_o  (position_o),
    .busy_res_o  (busy_res_o),
    .status_o    (status_o),
    .done_res_o  (done_res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side ready: random stalls, plus one long hold-off so the block
  // backs up into its input register and drops in_ready_o.
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = RX_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Both handshakes sampled at the edge; a result always trails its request
  // by the pipe latency, so noting first then checking is safe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(op_e'(op_i), direction_i, value_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(coils_o, position_o, busy_res_o, status_o, done_res_o);
    end
  end

  // Watchdog: any request, result or register transfer resets the count.
  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one request and return at the edge that accepts it. Valid is only
  // dropped when a gap is taken, so back-to-back requests keep it high.
  task automatic send_request(input op_e op, input logic dir, input logic [15:0] val);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    direction_i <= dir;
    value_i     <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_request(OP_TICK, 1'($urandom), 16'($urandom));
  endtask

  // Stop offering and wait until every owed result is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write, then read back the same register.
  task automatic reg_write(input reg_idx_e idx, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, v);
    if (idx == REG_MAX_POS) cur_max = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'h0, v}) begin
      $error("prdata: expected %h, got %h", {16'h0, v}, prdata);
      sb.fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(input logic [15:0] max_pos, input logic [15:0] ival,
                              input logic [15:0] sweep);
    reg_write(REG_MAX_POS, max_pos);
    reg_write(REG_STEP_IVAL, ival);
    reg_write(REG_HOME_SWEEP, sweep);
  endtask

  // Mostly ticks and well-aimed commands so moves and homing complete;
  // the rest is out-of-range targets, busy collisions and noise.
  task automatic send_random_request();
    int unsigned w;
    op_e         op;
    logic [15:0] val;
    w   = $urandom_range(99);
    val = 16'($urandom);
    if (w < 50)      op = OP_TICK;
    else if (w < 62) op = OP_STEP;
    else if (w < 74) op = OP_GOTO;
    else if (w < 80) op = OP_ABORT;
    else if (w < 85) op = OP_RELEASE;
    else if (w < 90) op = OP_HOME;
    else if (w < 97) op = OP_SETPOS;
    else             op = OP_NONE;
    if ((op == OP_GOTO || op == OP_SETPOS) && $urandom_range(99) < 85)
      val = 16'($urandom_range(32'(cur_max) + 1, 0));
    send_request(op, 1'($urandom), val);
  endtask

  // One chunk of random traffic under a fresh random setting.
  task automatic run_random_chunk();
    apply_config(16'($urandom_range(40, 0)), 16'($urandom_range(4, 0)),
                 16'($urandom_range(6, 0)));
    repeat (CHUNK_ITEMS) send_random_request();
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase A idling: sender 35, receiver 58
    tx_idle_pct = 35;
    rx_idle_pct = 58;

    // out of reset max_position is 0, so any goto is out of range
    send_request(OP_GOTO, 1'b0, 16'h0000);
    send_request(OP_TICK, 1'b1, 16'hFFFF);
    drain();

    apply_config(16'd100, 16'd2, 16'd3);
    send_request(OP_STEP, 1'b0, 16'h0000);     // backward at zero: limit
    send_request(OP_STEP, 1'b1, 16'h0000);     // forward, now waiting
    send_request(OP_STEP, 1'b1, 16'h0000);     // every command busy-rejected
    send_request(OP_GOTO, 1'b0, 16'd5);
    send_request(OP_RELEASE, 1'b0, 16'h0000);
    send_request(OP_HOME, 1'b0, 16'h0000);
    send_request(OP_SETPOS, 1'b0, 16'h1234);
    send_request(OP_ABORT, 1'b0, 16'h0000);    // ignored outside a goto
    send_request(OP_NONE, 1'b1, 16'hFFFF);
    run_ticks(2);                              // wait ends with done
    send_request(OP_GOTO, 1'b0, 16'd1);        // already there
    send_request(OP_GOTO, 1'b0, 16'd100);      // just out of range
    send_request(OP_GOTO, 1'b1, 16'hFFFF);
    send_request(OP_GOTO, 1'b0, 16'd4);
    run_ticks(3);
    send_request(OP_ABORT, 1'b1, 16'h0000);    // goto aborted, coils held
    send_request(OP_RELEASE, 1'b0, 16'h0000);
    send_request(OP_SETPOS, 1'b0, 16'hFFFF);   // loaded beyond max
    send_request(OP_STEP, 1'b1, 16'h0000);     // forward past top: limit
    send_request(OP_HOME, 1'b0, 16'h0000);
    run_ticks(6);
    drain();

    // zero interval behaves as one tick; zero sweep homes at once
    apply_config(16'd100, 16'd0, 16'd0);
    send_request(OP_HOME, 1'b0, 16'h0000);
    send_request(OP_SETPOS, 1'b0, 16'd2);
    send_request(OP_GOTO, 1'b0, 16'd10);
    drain();
    // goto still running: lower the top so its next phase hits the limit
    reg_write(REG_MAX_POS, 16'd4);
    run_ticks(2);
    drain();

    // widest range and longest interval: stop a slow goto by abort
    apply_config(16'hFFFF, 16'hFFFF, 16'd2);
    send_request(OP_SETPOS, 1'b0, 16'hFFFE);
    send_request(OP_STEP, 1'b1, 16'h0000);     // top position is max minus one
    send_request(OP_GOTO, 1'b0, 16'h0000);
    run_ticks(3);
    send_request(OP_ABORT, 1'b0, 16'h0000);
    drain();

    repeat (CHUNKS_PER_PH) run_random_chunk();

    // phase B: idle rates swapped
    tx_idle_pct = 58;
    rx_idle_pct = 35;
    repeat (CHUNKS_PER_PH) run_random_chunk();

    // phase C: no idling, plus one long result hold-off under full offer
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= 1'b1;
    repeat (CHUNKS_PER_PH) run_random_chunk();

    // start of a full-width homing sweep, stepped at interval one
    apply_config(16'd16, 16'd1, 16'hFFFF);
    send_request(OP_HOME, 1'b0, 16'h0000);
    run_ticks(HOME_TICKS);
    drain();

    if (sb.fail_count == 0 && sb.expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
